>>> src/mvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvam_pkg
// shared widths, codes and transaction types of the mirrored volume address map
// ----------------------------------------------------------------------------
package mvam_pkg;

    localparam int COORD_BITS = 23;
    localparam int SIZE_BITS  = 21;
    localparam int CNT_BITS   = 3;
    localparam int REP_BITS   = 2;
    localparam int MAX_MIRROR = 4;
    localparam int DIV_BITS   = COORD_BITS - 1;
    localparam int WIDE_BITS  = COORD_BITS + 3;
    localparam int STAT_BITS  = 3;
    localparam int IDX_BITS   = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_ABITS = 2;
    localparam int FIFO_CBITS = 3;
    localparam int IN_TDATA_BITS  = 136;
    localparam int OUT_TDATA_BITS = 80;

    localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_BAD      = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_MISALIGN = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_CROSS    = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_RANGE    = 3'd4;

    localparam logic [IDX_BITS-1:0] REG_ORIG_I   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ORIG_J   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ORIG_K   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_MIRROR_I = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MIRROR_J = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_MIRROR_K = 3'd5;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic                          kind;
        logic [2:0][COORD_BITS-1:0]    start;
        logic [2:0][SIZE_BITS-1:0]     size;
        logic [2:0]                    bad;
    } job_t;

    typedef struct packed {
        logic [2:0][SIZE_BITS-1:0]     orig;
        logic [2:0][CNT_BITS-1:0]      mcount;
    } cfg_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0]    start;
        logic [2:0][REP_BITS-1:0]      rep;
        logic [STAT_BITS-1:0]          status;
        logic                          last;
    } res_t;

endpackage
`default_nettype wire

>>> src/mvam_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvam_front
// unpacks an input transaction and flags bad start or size per axis
// ----------------------------------------------------------------------------
module mvam_front
    import mvam_pkg::*;
(
    input  wire logic [IN_TDATA_BITS-1:0] tdata,
    input  wire logic                     tuser,
    output job_t                          job
);

    always_comb
    begin
        job.kind = tuser;
        for (int d = 0; d < 3; d++)
        begin
            job.start[d] = tdata[d*COORD_BITS +: COORD_BITS];
            job.size[d]  = tdata[3*COORD_BITS + d*SIZE_BITS +: SIZE_BITS];
            job.bad[d]   = job.start[d][COORD_BITS-1] || (job.size[d] == '0);
        end
    end

endmodule
`default_nettype wire

>>> src/mvam_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvam_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
module mvam_fifo
    import mvam_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire job_t                  push_job,
    input  wire logic                  pop,
    output job_t                       pop_job,
    output logic [FIFO_CBITS-1:0]      count
);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_ABITS-1:0] wptr_reg, rptr_reg;
    logic [FIFO_CBITS-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_job;
    end

    assign pop_job = mem_reg[rptr_reg];
    assign count   = cnt_reg;

endmodule
`default_nettype wire

>>> src/mvam_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvam_back
// read checks through bit-serial dividers, write replica sequencer, output register
// ----------------------------------------------------------------------------
module mvam_back
    import mvam_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   job_avail,
    input  wire job_t   job,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output res_t        out_res
);

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_RDOUT, B_WROUT} bstate_t;

    localparam logic signed [WIDE_BITS-1:0] W_CMAX = WIDE_BITS'(2**(COORD_BITS-1) - 1);
    localparam logic signed [WIDE_BITS-1:0] W_CMIN = -W_CMAX - 1;
    localparam logic [4:0] DIV_LAST = 5'(DIV_BITS - 1);

    bstate_t                          state_reg;
    job_t                             job_reg;
    logic [2:0][DIV_BITS-1:0]         dvd_reg;
    logic [2:0][SIZE_BITS-1:0]        rems_reg, remo_reg;
    logic [2:0][DIV_BITS-1:0]         quo_reg;
    logic [4:0]                       step_reg;
    logic [2:0][REP_BITS-1:0]         rep_reg;
    logic                             out_valid_reg;
    res_t                             out_reg;

    logic                             slot_free;
    logic                             out_load;
    logic [2:0][CNT_BITS-1:0]         cnt;
    logic                             any_zero;
    logic [2:0]                       at_end;
    logic [2:0][SIZE_BITS-1:0]        rems_next, remo_next;
    logic [2:0]                       qbit;
    res_t                             rd_res, wr_res;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = slot_free && ((state_reg == B_RDOUT) || (state_reg == B_WROUT));

    // bit-serial restoring division steps
    always_comb
    begin
        logic [DIV_BITS-1:0] sh;
        for (int d = 0; d < 3; d++)
        begin
            sh = {rems_reg[d], dvd_reg[d][DIV_BITS-1]};
            if (sh >= DIV_BITS'(job_reg.size[d]))
                rems_next[d] = SIZE_BITS'(sh - DIV_BITS'(job_reg.size[d]));
            else
                rems_next[d] = SIZE_BITS'(sh);
            sh = {remo_reg[d], dvd_reg[d][DIV_BITS-1]};
            qbit[d] = (sh >= DIV_BITS'(cfg.orig[d]));
            if (qbit[d])
                remo_next[d] = SIZE_BITS'(sh - DIV_BITS'(cfg.orig[d]));
            else
                remo_next[d] = SIZE_BITS'(sh);
        end
    end

    // read result
    always_comb
    begin
        logic [2:0][STAT_BITS-1:0] ax;
        logic [DIV_BITS-1:0]       span;
        rd_res        = '0;
        rd_res.last   = 1'b1;
        rd_res.status = ST_OK;
        for (int d = 0; d < 3; d++)
        begin
            span = DIV_BITS'(remo_reg[d]) + DIV_BITS'(job_reg.size[d]);
            if (job_reg.bad[d])
                ax[d] = ST_BAD;
            else if (rems_reg[d] != '0)
                ax[d] = ST_MISALIGN;
            else if (cfg.orig[d] == '0)
                ax[d] = ST_RANGE;
            else if (span > DIV_BITS'(cfg.orig[d]))
                ax[d] = ST_CROSS;
            else if (quo_reg[d] >= DIV_BITS'(MAX_MIRROR))
                ax[d] = ST_RANGE;
            else
                ax[d] = ST_OK;
        end
        if (ax[0] != ST_OK)
            rd_res.status = ax[0];
        else if (ax[1] != ST_OK)
            rd_res.status = ax[1];
        else if (ax[2] != ST_OK)
            rd_res.status = ax[2];
        if (rd_res.status == ST_OK)
        begin
            for (int d = 0; d < 3; d++)
            begin
                rd_res.rep[d] = quo_reg[d][REP_BITS-1:0];
                if (quo_reg[d][0])
                    rd_res.start[d] = COORD_BITS'(cfg.orig[d]) - COORD_BITS'(remo_reg[d])
                                      - COORD_BITS'(job_reg.size[d]);
                else
                    rd_res.start[d] = COORD_BITS'(remo_reg[d]);
            end
        end
    end

    // write result for the current replica
    always_comb
    begin
        logic [CNT_BITS-1:0]          k;
        logic [WIDE_BITS-1:0]         prod;
        logic signed [WIDE_BITS-1:0]  v, s, sz;
        wr_res        = '0;
        wr_res.status = ST_OK;
        wr_res.rep    = rep_reg;
        for (int d = 0; d < 3; d++)
        begin
            k    = rep_reg[d][0] ? CNT_BITS'(rep_reg[d]) + 1'b1 : CNT_BITS'(rep_reg[d]);
            prod = WIDE_BITS'(cfg.orig[d]) * WIDE_BITS'(k);
            s    = WIDE_BITS'($signed(job_reg.start[d]));
            sz   = WIDE_BITS'(job_reg.size[d]);
            if (rep_reg[d][0])
                v = $signed(prod) - s - sz;
            else
                v = $signed(prod) + s;
            if (v > W_CMAX)
            begin
                v = W_CMAX;
                wr_res.status = ST_RANGE;
            end
            if (v < W_CMIN)
            begin
                v = W_CMIN;
                wr_res.status = ST_RANGE;
            end
            wr_res.start[d] = COORD_BITS'(v);
        end
        wr_res.last = &at_end;
    end

    always_comb
    begin
        any_zero = 1'b0;
        for (int d = 0; d < 3; d++)
        begin
            cnt[d]    = (cfg.mcount[d] > CNT_BITS'(MAX_MIRROR)) ? CNT_BITS'(MAX_MIRROR)
                                                                : cfg.mcount[d];
            any_zero  = any_zero || (cnt[d] == '0);
            at_end[d] = (CNT_BITS'(rep_reg[d]) == cnt[d] - 1'b1);
        end
    end

    assign pop = (state_reg == B_IDLE) && job_avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_avail)
                    begin
                        step_reg <= '0;
                        if (job.kind == KIND_READ)
                            state_reg <= B_DIV;
                        else if (!any_zero)
                            state_reg <= B_WROUT;
                    end
                end
                B_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == DIV_LAST)
                        state_reg <= B_RDOUT;
                end
                B_RDOUT:
                begin
                    if (slot_free)
                    begin
                        out_reg   <= rd_res;
                        state_reg <= B_IDLE;
                    end
                end
                B_WROUT:
                begin
                    if (slot_free)
                    begin
                        out_reg <= wr_res;
                        if (&at_end)
                            state_reg <= B_IDLE;
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= job;
            rep_reg  <= '0;
            rems_reg <= '0;
            remo_reg <= '0;
            quo_reg  <= '0;
            for (int d = 0; d < 3; d++)
                dvd_reg[d] <= job.start[d][DIV_BITS-1:0];
        end
        if (state_reg == B_DIV)
        begin
            rems_reg <= rems_next;
            remo_reg <= remo_next;
            for (int d = 0; d < 3; d++)
            begin
                dvd_reg[d] <= {dvd_reg[d][DIV_BITS-2:0], 1'b0};
                quo_reg[d] <= {quo_reg[d][DIV_BITS-2:0], qbit[d]};
            end
        end
        if (state_reg == B_WROUT && slot_free)
        begin
            if (!at_end[2])
                rep_reg[2] <= rep_reg[2] + 1'b1;
            else
            begin
                rep_reg[2] <= '0;
                if (!at_end[1])
                    rep_reg[1] <= rep_reg[1] + 1'b1;
                else
                begin
                    rep_reg[1] <= '0;
                    rep_reg[0] <= rep_reg[0] + 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule
`default_nettype wire

>>> src/mirrored_volume_address_map_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mirrored_volume_address_map_top
// maps box accesses on a mirrored volume onto the original volume
// ----------------------------------------------------------------------------
// read: 1 result, produced by dequeue, 22 bit-serial divider steps and the output
//   register load; the back end takes no new job until that result is loaded
// write: one result per cycle per replica while the output is not stalled, up to 64;
//   the back end takes no new job until the last replica result is loaded
// a 4-entry job queue lets input transactions be taken while the back end works
// reset: asynchronous, active low; sizes and mirror counts reset to 1, queue empty
// ----------------------------------------------------------------------------
module mirrored_volume_address_map_top
    import mvam_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [IDX_BITS-1:0]       cfg_addr,
    input  wire logic [SIZE_BITS-1:0]      cfg_wdata,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_i, start_j, start_k, size_i, size_j, size_k, zero fill
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // kind
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // mapped_start_i, mapped_start_j, mapped_start_k, replica_i, replica_j,
    // replica_k, status, zero fill
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
    output logic                           m_axis_tlast
);

    cfg_t                  cfg_reg;
    job_t                  in_job, q_job;
    logic                  push, pop;
    logic [FIFO_CBITS-1:0] q_count;
    res_t                  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < 3; d++)
            begin
                cfg_reg.orig[d]   <= SIZE_BITS'(1);
                cfg_reg.mcount[d] <= CNT_BITS'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ORIG_I:   cfg_reg.orig[0]   <= cfg_wdata;
                REG_ORIG_J:   cfg_reg.orig[1]   <= cfg_wdata;
                REG_ORIG_K:   cfg_reg.orig[2]   <= cfg_wdata;
                REG_MIRROR_I: cfg_reg.mcount[0] <= cfg_wdata[CNT_BITS-1:0];
                REG_MIRROR_J: cfg_reg.mcount[1] <= cfg_wdata[CNT_BITS-1:0];
                REG_MIRROR_K: cfg_reg.mcount[2] <= cfg_wdata[CNT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    assign s_axis_tready = (q_count != FIFO_CBITS'(FIFO_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;

    mvam_front u_front
    (
        .tdata (s_axis_tdata),
        .tuser (s_axis_tuser),
        .job   (in_job)
    );

    mvam_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (in_job),
        .pop      (pop),
        .pop_job  (q_job),
        .count    (q_count)
    );

    mvam_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_avail (q_count != '0),
        .job       (q_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.status, res.rep[2], res.rep[1], res.rep[0],
                           res.start[2], res.start[1], res.start[0]};
    assign m_axis_tlast = res.last;

    // the back end never dequeues from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_count != '0))
        else $error("dequeue from empty job queue");

    // input stalls only when the queue is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (q_count == FIFO_CBITS'(FIFO_DEPTH)))
        else $error("input stalled with room in the queue");

    // a queue entry taken without a push cannot leave the count unchanged
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (q_count == $past(q_count) - 1'b1))
        else $error("queue count out of step");

endmodule
`default_nettype wire
